// ===== rtl/core/cvcc_pkg.sv =====
`default_nettype none
package cvcc_pkg;

  // input item kinds, kind 3 carries no meaning
  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_REMAP  = 2'd2
  } kind_t;

  // operations handed from front to back
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_REMAP  = 1'b1
  } op_t;

  localparam int CH_W    = 4;
  localparam int CFG_I_W = 4;
  localparam int CFG_D_W = 32;

  // configuration register indexes
  localparam logic [CFG_I_W-1:0] CFG_PHASE_STEP   = 4'd0;
  localparam logic [CFG_I_W-1:0] CFG_MIDI_CHANNEL = 4'd1;

  localparam logic [31:0] STEP_RESET = 32'd8947849;
  localparam logic [3:0]  STATUS_CC  = 4'hB;
  localparam logic [7:0]  LAST_NONE  = 8'hFF;

  // configuration write request
  typedef struct packed {
    logic               en;
    logic [CFG_I_W-1:0] index;
    logic [CFG_D_W-1:0] data;
  } cfg_write_t;

  // queue entry: data is the quantized value or the new controller number
  typedef struct packed {
    op_t             op;
    logic [CH_W-1:0] ch;
    logic [6:0]      data;
  } work_t;

endpackage
`default_nettype wire

// ===== rtl/core/cvcc_front.sv =====
`default_nettype none
module cvcc_front
  import cvcc_pkg::*;
#(
  parameter int CHANNELS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_write_t  cfg,
  input  wire logic        accept,
  input  wire logic [1:0]  kind,
  input  wire logic [3:0]  channel,
  input  wire logic [15:0] voltage,
  input  wire logic [6:0]  controller_number,
  output work_t            push_entry,
  output logic             push
);

  localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

  logic [31:0] phase_step;
  logic [31:0] phase_acc;
  logic        window_open;
  logic [32:0] phase_sum;
  logic        ch_ok;
  logic        is_tick;

  // quantizer signals
  logic [14:0] v_mag;
  logic [21:0] scaled;
  logic [11:0] scaled_k;
  logic [24:0] recip_prod;
  logic [8:0]  quot;
  logic [6:0]  cc_q;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= STEP_RESET;
    end else if (cfg.en && cfg.index == CFG_PHASE_STEP) begin
      phase_step <= cfg.data[31:0];
    end
  end

  // phase accumulator, carry opens the window for one frame
  assign phase_sum = {1'b0, phase_acc} + {1'b0, phase_step};
  assign is_tick   = (kind_t'(kind) == KIND_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc   <= '0;
      window_open <= 1'b0;
    end else if (accept && is_tick) begin
      phase_acc   <= phase_sum[31:0];
      window_open <= phase_sum[32];
    end
  end

  // round(v*127/10240) for positive v: /1024 by shift, /10 by reciprocal
  assign v_mag      = voltage[14:0];
  assign scaled     = ({v_mag, 7'd0} - {7'd0, v_mag}) + 22'd5120;
  assign scaled_k   = scaled[21:10];
  assign recip_prod = {13'd0, scaled_k} * 25'd6554;
  assign quot       = recip_prod[24:16];

  always_comb begin
    if (voltage[15] || voltage == 16'd0) begin
      cc_q = 7'd0;
    end else if (quot > 9'd127) begin
      cc_q = 7'd127;
    end else begin
      cc_q = quot[6:0];
    end
  end

  // classify the request
  assign ch_ok = ({3'd0, channel} < CH_LIMIT);

  always_comb begin
    push            = 1'b0;
    push_entry.op   = OP_SAMPLE;
    push_entry.ch   = channel;
    push_entry.data = cc_q;
    unique case (kind_t'(kind))
      KIND_SAMPLE: begin
        push = accept && ch_ok && window_open;
      end
      KIND_REMAP: begin
        push            = accept && ch_ok;
        push_entry.op   = OP_REMAP;
        push_entry.data = controller_number;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  a_carry_opens: assert property (@(posedge clk) disable iff (rst)
    (accept && is_tick && phase_sum[32]) |=> window_open)
    else $error("tick carry did not open the window");

  a_push_window: assert property (@(posedge clk) disable iff (rst)
    (push && push_entry.op == OP_SAMPLE) |-> window_open)
    else $error("sample forwarded with the window closed");

endmodule
`default_nettype wire

// ===== rtl/core/cvcc_queue.sv =====
`default_nettype none
module cvcc_queue
  import cvcc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire work_t push_entry,
  input  wire logic  pop,
  output work_t      head,
  output logic       not_empty,
  output logic       full
);

  work_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (full && !pop) |-> !push)
    else $error("push into full queue");

endmodule
`default_nettype wire

// ===== rtl/core/cvcc_back.sv =====
`default_nettype none
module cvcc_back
  import cvcc_pkg::*;
#(
  parameter int CHANNELS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_write_t cfg,
  input  wire work_t      head,
  input  wire logic       not_empty,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      status_byte,
  output logic [6:0]      controller,
  output logic [6:0]      cc_value
);

  // only channel codes that fit the channel field can reach the tables
  localparam int DEPTH = (CHANNELS < 16) ? CHANNELS : 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [3:0]       midi_channel;
  logic [7:0]       last_sent [DEPTH];
  logic [6:0]       ctrl_map  [DEPTH];
  logic [IDX_W-1:0] idx;
  logic             differs;
  logic             send;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      midi_channel <= 4'd0;
    end else if (cfg.en && cfg.index == CFG_MIDI_CHANNEL) begin
      midi_channel <= cfg.data[3:0];
    end
  end

  assign idx     = head.ch[IDX_W-1:0];
  assign pop     = not_empty && (!out_valid || out_ready);
  assign differs = ({1'b0, head.data} != last_sent[idx]);
  assign send    = pop && head.op == OP_SAMPLE && differs;

  // per-channel tables
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < DEPTH; n++) begin
        last_sent[n] <= LAST_NONE;
        ctrl_map[n]  <= 7'(n);
      end
    end else if (pop) begin
      if (head.op == OP_REMAP) begin
        ctrl_map[idx] <= head.data;
      end else if (differs) begin
        last_sent[idx] <= {1'b0, head.data};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (send) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      status_byte <= {STATUS_CC, midi_channel};
      controller  <= ctrl_map[idx];
      cc_value    <= head.data;
    end
  end

  a_sent_recorded: assert property (@(posedge clk) disable iff (rst)
    send |=> (out_valid && {1'b0, cc_value} == last_sent[$past(idx)]))
    else $error("sent value not recorded for its channel");

endmodule
`default_nettype wire

// ===== rtl/core/cv_to_midi_cc_converter.sv =====
// a sample that sends is stored in a queue slot and then registered in the output register
// throughput: one request per cycle while the queue is not full; a stalled output holds two requests in the queue
// ticks update the phase accumulator in the front and reach no further
// configuration writes are taken every cycle and act the next cycle
// reset (synchronous): window closed, phase zero, all channels unsent, identity map
`default_nettype none
module cv_to_midi_cc_converter
  import cvcc_pkg::*;
#(
  parameter int CHANNELS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [3:0]  channel,
  input  wire logic [15:0] voltage,
  input  wire logic [6:0]  controller_number,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       status_byte,
  output logic [6:0]       controller,
  output logic [6:0]       cc_value
);

  cfg_write_t cfg;
  work_t      push_entry;
  work_t      head;
  logic       push;
  logic       pop;
  logic       not_empty;
  logic       full;
  logic       accept;

  // configuration request
  assign cfg_ready  = 1'b1;
  assign cfg.en     = cfg_valid;
  assign cfg.index  = cfg_index;
  assign cfg.data   = cfg_data;

  // input request taken whenever the queue has room
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  cvcc_front #(.CHANNELS(CHANNELS)) u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .accept           (accept),
    .kind             (kind),
    .channel          (channel),
    .voltage          (voltage),
    .controller_number(controller_number),
    .push_entry       (push_entry),
    .push             (push)
  );

  cvcc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  cvcc_back #(.CHANNELS(CHANNELS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .not_empty  (not_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status_byte(status_byte),
    .controller (controller),
    .cc_value   (cc_value)
  );

endmodule
`default_nettype wire

// ===== sim/tb_cv_to_midi_cc_converter.sv =====
`default_nettype none
module tb_cv_to_midi_cc_converter;
  import cvcc_pkg::*;

  localparam int NUM_CH = 16;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES = 8;
  localparam int PHASE_REQUESTS = 175;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [CFG_I_W-1:0] CFG_UNUSED = 4'd9;

  // one input request
  typedef struct {
    logic [1:0]  k;
    logic [3:0]  ch;
    logic [15:0] volt;
    logic [6:0]  cnum;
  } cv_request_t;

  // one control change message
  typedef struct {
    logic [7:0] status;
    logic [6:0] ctrl;
    logic [6:0] value;
  } cc_msg_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = '0;
  logic [3:0]  channel = '0;
  logic [15:0] voltage = '0;
  logic [6:0]  controller_number = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  status_byte;
  logic [6:0]  controller;
  logic [6:0]  cc_value;

  cv_request_t pending_requests[$];
  cc_msg_t     expected_cc[$];
  cv_request_t next_request;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          in_gap = 0;
  int          out_hold = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  // converter state mirror
  logic [31:0] cfg_step;
  logic [3:0]  cfg_midi;
  logic [31:0] phase_acc;
  logic        window_open;
  logic [7:0]  last_sent[NUM_CH];
  logic [6:0]  ctrl_map[NUM_CH];

  cv_to_midi_cc_converter #(.CHANNELS(NUM_CH)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .channel(channel),
    .voltage(voltage),
    .controller_number(controller_number),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status_byte(status_byte),
    .controller(controller),
    .cc_value(cc_value)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_failure(string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  task automatic reset_mirror();
    cfg_step = STEP_RESET;
    cfg_midi = 4'd0;
    phase_acc = 32'd0;
    window_open = 1'b0;
    for (int n = 0; n < NUM_CH; n++) begin
      last_sent[n] = LAST_NONE;
      ctrl_map[n] = 7'(n);
    end
  endtask

  // round(v * 127 / 10240) with v in 1/1024 volt, clamped to 0..127
  function automatic logic [6:0] scale_cv(logic [15:0] raw);
    int v;
    int q;
    v = int'($signed(raw));
    if (v <= 0) return 7'd0;
    q = (v * 127 + 5120) / 10240;
    return (q > 127) ? 7'd127 : 7'(q);
  endfunction

  // expected control change for one accepted request
  task automatic predict_cc_message(cv_request_t r);
    logic [32:0] sum;
    logic [6:0]  val;
    cc_msg_t     m;
    if (r.k == KIND_TICK) begin
      sum = {1'b0, phase_acc} + {1'b0, cfg_step};
      window_open = sum[32];
      phase_acc = sum[31:0];
    end else if (r.k == KIND_REMAP) begin
      ctrl_map[r.ch] = r.cnum;
    end else if (r.k == KIND_SAMPLE && window_open) begin
      val = scale_cv(r.volt);
      if ({1'b0, val} != last_sent[r.ch]) begin
        last_sent[r.ch] = {1'b0, val};
        m.status = {STATUS_CC, cfg_midi};
        m.ctrl = ctrl_map[r.ch];
        m.value = val;
        expected_cc.push_back(m);
      end
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready)
        predict_cc_message('{kind, channel, voltage, controller_number});
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          next_request = pending_requests.pop_front();
          kind <= next_request.k;
          channel <= next_request.ch;
          voltage <= next_request.volt;
          controller_number <= next_request.cnum;
          in_valid <= 1'b1;
          in_gap <= in_calm ? 0 : $urandom_range(0, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_cc.size() == 0) begin
          report_failure($sformatf("unexpected cc %02h %0d %0d",
                                   status_byte, controller, cc_value));
        end else begin
          cc_msg_t m;
          m = expected_cc.pop_front();
          if (status_byte !== m.status)
            report_failure($sformatf("status got %02h want %02h", status_byte, m.status));
          if (controller !== m.ctrl)
            report_failure($sformatf("controller got %0d want %0d", controller, m.ctrl));
          if (cc_value !== m.value)
            report_failure($sformatf("cc value got %0d want %0d", cc_value, m.value));
        end
        out_hold = out_calm ? 0 : $urandom_range(0, 10);
      end else if (out_hold > 0) begin
        out_hold = out_hold - 1;
      end
      out_ready <= (out_hold == 0);
    end
  end

  task automatic push_request(logic [1:0] k, logic [3:0] ch, logic [15:0] v,
                              logic [6:0] cn);
    cv_request_t r;
    r.k = k;
    r.ch = ch;
    r.volt = v;
    r.cnum = cn;
    pending_requests.push_back(r);
  endtask

  // register write, only while the converter is idle
  task automatic write_config(logic [3:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PHASE_STEP) cfg_step = data;
    else if (idx == CFG_MIDI_CHANNEL) cfg_midi = data[3:0];
  endtask

  // wait for all requests to drain and all messages to arrive
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_cc.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // voltages biased toward step boundaries and the clamp
  function automatic logic [15:0] pick_voltage();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 1400));
      2: return 16'($urandom_range(10150, 10300));
      3: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          3: return 16'h0001;
          default: return 16'hFFFF;
        endcase
      end
      4: return 16'(-$urandom_range(0, 2000));
      default: return 16'($urandom_range(0, 10240));
    endcase
  endfunction

  // mostly frames of one tick and a few samples, the rest noise
  task automatic queue_random_requests(int count);
    int done;
    int len;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 9) < 7) begin
        push_request(KIND_TICK, 4'($urandom), 16'($urandom), 7'($urandom));
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 7) == 0)
            push_request(KIND_REMAP, 4'($urandom), 16'($urandom), 7'($urandom));
          else
            push_request(KIND_SAMPLE, 4'($urandom), pick_voltage(), 7'($urandom));
        end
        done += len + 1;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            push_request(KIND_UNUSED, 4'($urandom), 16'($urandom), 7'($urandom));
          end
          1: begin
            push_request(KIND_TICK, 4'($urandom), 16'($urandom), 7'($urandom));
            done++;
          end
          2: begin
            push_request(KIND_REMAP, 4'($urandom), 16'($urandom), 7'($urandom));
            done++;
          end
          default: begin
            push_request(KIND_SAMPLE, 4'($urandom), pick_voltage(), 7'($urandom));
            done++;
          end
        endcase
      end
    end
  endtask

  // stimulus
  initial begin
    logic [31:0] step;
    reset_mirror();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: window closed, samples ignored
    push_request(KIND_SAMPLE, 4'd0, 16'd5000, 7'd0);
    push_request(KIND_UNUSED, 4'd15, 16'hFFFF, 7'h7F);
    push_request(KIND_REMAP, 4'd3, 16'd0, 7'd127);
    push_request(KIND_TICK, 4'd0, 16'd0, 7'd0);
    push_request(KIND_SAMPLE, 4'd1, 16'd2000, 7'd0);
    wait_idle();

    write_config(CFG_PHASE_STEP, 32'hFFFF_FFFF);
    write_config(CFG_MIDI_CHANNEL, 32'h0000_000F);
    write_config(CFG_UNUSED, $urandom);

    // phase already nonzero, so both ticks carry and keep the window open
    push_request(KIND_TICK, 4'd0, 16'd0, 7'd0);
    push_request(KIND_SAMPLE, 4'd2, 16'd3000, 7'd0);
    push_request(KIND_TICK, 4'd0, 16'd0, 7'd0);
    // first value always sent, even zero; repeat suppressed
    push_request(KIND_SAMPLE, 4'd0, 16'd0, 7'd0);
    push_request(KIND_SAMPLE, 4'd0, 16'd0, 7'd0);
    push_request(KIND_SAMPLE, 4'd1, 16'h8000, 7'd0);
    push_request(KIND_SAMPLE, 4'd2, 16'h7FFF, 7'd0);
    // rounding edges and the clamp
    push_request(KIND_SAMPLE, 4'd3, 16'd40, 7'd0);
    push_request(KIND_SAMPLE, 4'd3, 16'd41, 7'd0);
    push_request(KIND_SAMPLE, 4'd4, 16'd10199, 7'd0);
    push_request(KIND_SAMPLE, 4'd5, 16'hFFFF, 7'd0);
    push_request(KIND_REMAP, 4'd4, 16'd0, 7'd0);
    push_request(KIND_SAMPLE, 4'd4, 16'd10200, 7'd0);
    push_request(KIND_SAMPLE, 4'd15, 16'h7FFF, 7'd0);
    push_request(KIND_UNUSED, 4'd15, 16'd100, 7'd5);
    push_request(KIND_TICK, 4'd15, 16'hFFFF, 7'h7F);
    push_request(KIND_SAMPLE, 4'd15, 16'd5120, 7'd0);
    wait_idle();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: step = 32'h8000_0000;
        1: step = 32'h0000_0001;
        2: step = 32'hFFFF_FFFF;
        3: step = STEP_RESET;
        4: step = $urandom_range(1, 32'hFFFF_FFFF);
        5: step = 32'hC000_0000;
        6: step = $urandom_range(32'h2000_0000, 32'hFFFF_FFFF);
        default: step = 32'hFFFF_FFFF;
      endcase
      write_config(CFG_PHASE_STEP, step);
      case (phase)
        0: write_config(CFG_MIDI_CHANNEL, 32'h0000_0000);
        3: write_config(CFG_MIDI_CHANNEL, 32'h0000_000F);
        default: write_config(CFG_MIDI_CHANNEL, $urandom);
      endcase
      in_calm = (phase % 3 == 1);
      out_calm = (phase % 4 == 2);
      queue_random_requests(PHASE_REQUESTS);
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== cv_to_midi_cc_converter.f =====
rtl/core/cvcc_pkg.sv
rtl/core/cvcc_front.sv
rtl/core/cvcc_queue.sv
rtl/core/cvcc_back.sv
rtl/core/cv_to_midi_cc_converter.sv
sim/tb_cv_to_midi_cc_converter.sv
